// ----- src/qsg_pkg.sv -----
// ----------------------------------------------------------------------------
// qsg_pkg
// Shared types and constants for the quadrature sine generator: field widths,
// register map, fixed-point constants, sequencer states and control bundle.
// ----------------------------------------------------------------------------
package qsg_pkg;

    // field and datapath widths
    localparam int STEP_W     = 31;
    localparam int GAIN_W     = 28;
    localparam int OFFS_W     = 29;
    localparam int SMP_W      = 30;
    localparam int PHS_W      = 32;
    localparam int PROD_W     = 64;
    localparam int MAG_W      = 36;
    localparam int ADDR_W     = 4;
    localparam int APB_DATA_W = 32;

    // renormalization period in ticks
    localparam int RENORM_PERIOD = 256;
    localparam int CNT_W         = $clog2(RENORM_PERIOD);

    // register map, index is paddr[3:2]
    typedef enum logic [1:0] {
        REG_STEP_SINE   = 2'd0,
        REG_STEP_COSINE = 2'd1,
        REG_GAIN        = 2'd2,
        REG_OFFSET      = 2'd3
    } reg_idx_t;

    // register reset values
    localparam logic signed [STEP_W-1:0] STEP_SINE_RST   = 31'sd8432802;
    localparam logic signed [STEP_W-1:0] STEP_COSINE_RST = 31'sd536804679;
    localparam logic [GAIN_W-1:0]        GAIN_RST        = 28'd16777216;
    localparam logic signed [OFFS_W-1:0] OFFSET_RST      = 29'sd0;

    // fixed-point constants
    localparam logic signed [PHS_W-1:0]  ONE_Q29     = 32'sd536870912;
    localparam logic signed [PROD_W-1:0] HALF_Q29    = 64'sd268435456;
    localparam logic signed [PROD_W-1:0] HALF_Q30    = 64'sd536870912;
    localparam logic signed [PROD_W-1:0] THREE_Q29   = 64'sd1610612736;
    localparam logic signed [PROD_W-1:0] OUT_LIMIT   = 64'sd335544320;
    localparam logic signed [PROD_W-1:0] OUT_LIMIT_N = -64'sd335544320;
    localparam logic signed [PROD_W-1:0] SAT32_MAX   = 64'sd2147483647;
    localparam logic signed [PROD_W-1:0] SAT32_MIN   = -64'sd2147483648;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SMP_S,
        ST_SMP_C,
        ST_ROT_A,
        ST_ROT_B,
        ST_ROT_C,
        ST_ROT_D,
        ST_ROT_E,
        ST_MAG_A,
        ST_MAG_B,
        ST_MAG_C,
        ST_NRM_A,
        ST_NRM_B,
        ST_NRM_C,
        ST_DONE
    } state_t;

    // multiplier operand pairs
    typedef enum logic [3:0] {
        OP_NONE,
        OP_S_G,
        OP_C_G,
        OP_S_STC,
        OP_C_STS,
        OP_C_STC,
        OP_S_STS,
        OP_NS_NS,
        OP_NC_NC,
        OP_NS_CORR,
        OP_NC_CORR
    } op_t;

    // what to do with the product issued in the cycle before
    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_SMP_S,
        ACT_SMP_C,
        ACT_ACC_LOAD,
        ACT_ROT_NS,
        ACT_ROT_NC,
        ACT_MAG_LOAD,
        ACT_CORR,
        ACT_NRM_NS,
        ACT_NRM_NC
    } act_t;

    // sequencer to datapath control
    typedef struct packed {
        op_t  op;
        act_t act;
        logic commit;
    } ctrl_t;

    // configuration register bundle
    typedef struct packed {
        logic signed [STEP_W-1:0] step_sine;
        logic signed [STEP_W-1:0] step_cosine;
        logic [GAIN_W-1:0]        gain;
        logic signed [OFFS_W-1:0] offset;
    } cfg_t;

endpackage

// ----- src/quadrature_sine_generator_core.sv -----
// ----------------------------------------------------------------------------
// quadrature_sine_generator_core
// Rotation-recurrence quadrature oscillator with gain, offset and periodic
// amplitude renormalization.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready carry one tick beat per control period. A beat with
//   s_tick high yields one result beat on m_valid/m_ready holding
//   m_sine and m_cosine (signed Q6.24, saturated to +-20.0).
//   A beat with s_tick low is taken and produces no result.
//   m_valid rises once the sequencer has run its sample and rotation
//   states, and on every 256th tick also the renormalization pass.
//   A new tick is taken only once the last one is through; the pace is
//   set by the single shared 32x32 multiplier, which takes six
//   products per tick plus four for the renormalization, one per cycle.
//   s_ready is high only while the sequencer is idle.
//   The result sits in an output register; a new tick is taken while it
//   waits. If the receiver stalls, the following result waits in the
//   datapath and the block stops taking ticks until the output frees up.
//   Reset sets the phasor to (0, 1.0), clears the tick count and loads the
//   register defaults (50 Hz step at 20 kHz, gain 1.0, offset 0).
//   Registers sit on the APB port at 0x0 step_sine, 0x4 step_cosine,
//   0x8 amplitude_gain, 0xC offset; write them only while idle.
// ----------------------------------------------------------------------------
module quadrature_sine_generator_core (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // tick channel
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic                                  s_tick,
    // sample channel
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [qsg_pkg::SMP_W-1:0]      m_sine,
    output logic signed [qsg_pkg::SMP_W-1:0]      m_cosine,
    // configuration port
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [qsg_pkg::ADDR_W-1:0]            paddr,
    input  logic [qsg_pkg::APB_DATA_W-1:0]        pwdata,
    output logic [qsg_pkg::APB_DATA_W-1:0]        prdata,
    output logic                                  pready
);

    qsg_pkg::cfg_t                       cfg_reg;
    qsg_pkg::cfg_t                       cfg_next;
    qsg_pkg::reg_idx_t                   reg_idx;
    logic                                wr_en;

    qsg_pkg::ctrl_t                      ctrl;
    logic                                out_free;
    logic                                out_load;
    logic signed [qsg_pkg::SMP_W-1:0]    smp_s;
    logic signed [qsg_pkg::SMP_W-1:0]    smp_c;

    logic                                m_valid_reg, m_valid_next;
    logic signed [qsg_pkg::SMP_W-1:0]    m_sine_reg, m_sine_next;
    logic signed [qsg_pkg::SMP_W-1:0]    m_cosine_reg, m_cosine_next;

    // apb register write
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = qsg_pkg::reg_idx_t'(paddr[qsg_pkg::ADDR_W-1:2]);

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (reg_idx)
                qsg_pkg::REG_STEP_SINE:   cfg_next.step_sine   = pwdata[qsg_pkg::STEP_W-1:0];
                qsg_pkg::REG_STEP_COSINE: cfg_next.step_cosine = pwdata[qsg_pkg::STEP_W-1:0];
                qsg_pkg::REG_GAIN:        cfg_next.gain        = pwdata[qsg_pkg::GAIN_W-1:0];
                qsg_pkg::REG_OFFSET:      cfg_next.offset      = pwdata[qsg_pkg::OFFS_W-1:0];
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.step_sine   <= qsg_pkg::STEP_SINE_RST;
            cfg_reg.step_cosine <= qsg_pkg::STEP_COSINE_RST;
            cfg_reg.gain        <= qsg_pkg::GAIN_RST;
            cfg_reg.offset      <= qsg_pkg::OFFSET_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // apb register read
    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            qsg_pkg::REG_STEP_SINE: begin
                prdata = {{(qsg_pkg::APB_DATA_W-qsg_pkg::STEP_W){1'b0}}, cfg_reg.step_sine};
            end
            qsg_pkg::REG_STEP_COSINE: begin
                prdata = {{(qsg_pkg::APB_DATA_W-qsg_pkg::STEP_W){1'b0}}, cfg_reg.step_cosine};
            end
            qsg_pkg::REG_GAIN: begin
                prdata = {{(qsg_pkg::APB_DATA_W-qsg_pkg::GAIN_W){1'b0}}, cfg_reg.gain};
            end
            qsg_pkg::REG_OFFSET: begin
                prdata = {{(qsg_pkg::APB_DATA_W-qsg_pkg::OFFS_W){1'b0}}, cfg_reg.offset};
            end
            default: prdata = '0;
        endcase
    end

    // sequencer
    qsg_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_tick   (s_tick),
        .out_free (out_free),
        .s_ready  (s_ready),
        .out_load (out_load),
        .ctrl     (ctrl)
    );

    // datapath with the shared multiplier
    qsg_dpath u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .cfg     (cfg_reg),
        .smp_s   (smp_s),
        .smp_c   (smp_c)
    );

    // output beat register
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next  = m_valid_reg;
        m_sine_next   = m_sine_reg;
        m_cosine_next = m_cosine_reg;
        if (out_load) begin
            m_valid_next  = 1'b1;
            m_sine_next   = smp_s;
            m_cosine_next = smp_c;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_sine_reg   <= m_sine_next;
        m_cosine_reg <= m_cosine_next;
    end

    assign m_valid  = m_valid_reg;
    assign m_sine   = m_sine_reg;
    assign m_cosine = m_cosine_reg;

    // a loaded beat is always inside the saturation range
    a_out_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (aresetn && out_load) |=>
            (m_valid_reg &&
             m_sine_reg <= qsg_pkg::OUT_LIMIT && m_sine_reg >= qsg_pkg::OUT_LIMIT_N &&
             m_cosine_reg <= qsg_pkg::OUT_LIMIT && m_cosine_reg >= qsg_pkg::OUT_LIMIT_N))
        else $error("output beat outside saturation range");

endmodule

// ----- src/qsg_mult.sv -----
// ----------------------------------------------------------------------------
// qsg_mult
// Shared signed 32x32 multiplier with a registered 64-bit product.
// ----------------------------------------------------------------------------
module qsg_mult (
    input  logic                                 aclk,
    input  logic signed [qsg_pkg::PHS_W-1:0]     op_a,
    input  logic signed [qsg_pkg::PHS_W-1:0]     op_b,
    output logic signed [qsg_pkg::PROD_W-1:0]    prod
);

    logic signed [qsg_pkg::PROD_W-1:0] prod_reg;
    logic signed [qsg_pkg::PROD_W-1:0] prod_next;

    // full-width signed product
    always_comb begin
        prod_next = qsg_pkg::PROD_W'(op_a) * qsg_pkg::PROD_W'(op_b);
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

// ----- src/qsg_ctrl.sv -----
// ----------------------------------------------------------------------------
// qsg_ctrl
// Sequencer for one tick: issues the multiplier operand pairs in order,
// tells the datapath how to use each product and counts ticks between
// amplitude renormalizations.
// ----------------------------------------------------------------------------
module qsg_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    input  logic            s_tick,
    input  logic            out_free,
    output logic            s_ready,
    output logic            out_load,
    output qsg_pkg::ctrl_t  ctrl
);

    qsg_pkg::state_t             state_reg;
    qsg_pkg::state_t             state_next;
    logic [qsg_pkg::CNT_W-1:0]   cnt_reg;
    logic [qsg_pkg::CNT_W-1:0]   cnt_next;
    logic                        renorm_due;

    assign renorm_due = (cnt_reg == qsg_pkg::CNT_W'(qsg_pkg::RENORM_PERIOD - 1));

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            qsg_pkg::ST_IDLE: begin
                if (s_valid && s_tick) begin
                    state_next = qsg_pkg::ST_SMP_S;
                end
            end
            qsg_pkg::ST_SMP_S: state_next = qsg_pkg::ST_SMP_C;
            qsg_pkg::ST_SMP_C: state_next = qsg_pkg::ST_ROT_A;
            qsg_pkg::ST_ROT_A: state_next = qsg_pkg::ST_ROT_B;
            qsg_pkg::ST_ROT_B: state_next = qsg_pkg::ST_ROT_C;
            qsg_pkg::ST_ROT_C: state_next = qsg_pkg::ST_ROT_D;
            qsg_pkg::ST_ROT_D: state_next = qsg_pkg::ST_ROT_E;
            qsg_pkg::ST_ROT_E: begin
                state_next = renorm_due ? qsg_pkg::ST_MAG_A : qsg_pkg::ST_DONE;
            end
            qsg_pkg::ST_MAG_A: state_next = qsg_pkg::ST_MAG_B;
            qsg_pkg::ST_MAG_B: state_next = qsg_pkg::ST_MAG_C;
            qsg_pkg::ST_MAG_C: state_next = qsg_pkg::ST_NRM_A;
            qsg_pkg::ST_NRM_A: state_next = qsg_pkg::ST_NRM_B;
            qsg_pkg::ST_NRM_B: state_next = qsg_pkg::ST_NRM_C;
            qsg_pkg::ST_NRM_C: state_next = qsg_pkg::ST_DONE;
            qsg_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = qsg_pkg::ST_IDLE;
                end
            end
            default: state_next = qsg_pkg::ST_IDLE;
        endcase
    end

    // tick counter, advanced once per tick
    always_comb begin
        cnt_next = cnt_reg;
        if (state_reg == qsg_pkg::ST_ROT_E) begin
            cnt_next = renorm_due ? '0 : cnt_reg + 1'b1;
        end
    end

    // outputs per state
    always_comb begin
        s_ready     = (state_reg == qsg_pkg::ST_IDLE);
        out_load    = (state_reg == qsg_pkg::ST_DONE) && out_free;
        ctrl.op     = qsg_pkg::OP_NONE;
        ctrl.act    = qsg_pkg::ACT_NONE;
        ctrl.commit = 1'b0;
        unique case (state_reg)
            qsg_pkg::ST_IDLE: begin
            end
            qsg_pkg::ST_SMP_S: begin
                ctrl.op = qsg_pkg::OP_S_G;
            end
            qsg_pkg::ST_SMP_C: begin
                ctrl.op  = qsg_pkg::OP_C_G;
                ctrl.act = qsg_pkg::ACT_SMP_S;
            end
            qsg_pkg::ST_ROT_A: begin
                ctrl.op  = qsg_pkg::OP_S_STC;
                ctrl.act = qsg_pkg::ACT_SMP_C;
            end
            qsg_pkg::ST_ROT_B: begin
                ctrl.op  = qsg_pkg::OP_C_STS;
                ctrl.act = qsg_pkg::ACT_ACC_LOAD;
            end
            qsg_pkg::ST_ROT_C: begin
                ctrl.op  = qsg_pkg::OP_C_STC;
                ctrl.act = qsg_pkg::ACT_ROT_NS;
            end
            qsg_pkg::ST_ROT_D: begin
                ctrl.op  = qsg_pkg::OP_S_STS;
                ctrl.act = qsg_pkg::ACT_ACC_LOAD;
            end
            qsg_pkg::ST_ROT_E: begin
                ctrl.act = qsg_pkg::ACT_ROT_NC;
            end
            qsg_pkg::ST_MAG_A: begin
                ctrl.op = qsg_pkg::OP_NS_NS;
            end
            qsg_pkg::ST_MAG_B: begin
                ctrl.op  = qsg_pkg::OP_NC_NC;
                ctrl.act = qsg_pkg::ACT_MAG_LOAD;
            end
            qsg_pkg::ST_MAG_C: begin
                ctrl.act = qsg_pkg::ACT_CORR;
            end
            qsg_pkg::ST_NRM_A: begin
                ctrl.op = qsg_pkg::OP_NS_CORR;
            end
            qsg_pkg::ST_NRM_B: begin
                ctrl.op  = qsg_pkg::OP_NC_CORR;
                ctrl.act = qsg_pkg::ACT_NRM_NS;
            end
            qsg_pkg::ST_NRM_C: begin
                ctrl.act = qsg_pkg::ACT_NRM_NC;
            end
            qsg_pkg::ST_DONE: begin
                ctrl.commit = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= qsg_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // a tick beat starts the sequence and drops ready
    a_tick_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (aresetn && s_valid && s_ready && s_tick) |=>
            (state_reg == qsg_pkg::ST_SMP_S && !s_ready))
        else $error("tick beat did not start the sequence");

    // renormalization restarts the tick count
    a_renorm_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        (aresetn && state_reg == qsg_pkg::ST_ROT_E && renorm_due) |=>
            (cnt_reg == '0 && state_reg == qsg_pkg::ST_MAG_A))
        else $error("renormalization did not restart the tick count");

endmodule

// ----- src/qsg_dpath.sv -----
// ----------------------------------------------------------------------------
// qsg_dpath
// Oscillator datapath: phasor state, operand selection for the shared
// multiplier, rounding of each product, saturation of all results but the magnitude, sample registers.
// ----------------------------------------------------------------------------
module qsg_dpath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  qsg_pkg::ctrl_t                      ctrl,
    input  qsg_pkg::cfg_t                       cfg,
    output logic signed [qsg_pkg::SMP_W-1:0]    smp_s,
    output logic signed [qsg_pkg::SMP_W-1:0]    smp_c
);

    // round half up and drop 29 fraction bits
    function automatic logic signed [qsg_pkg::PROD_W-1:0] rnd29(
        input logic signed [qsg_pkg::PROD_W-1:0] v
    );
        logic signed [qsg_pkg::PROD_W-1:0] t;
        t = v + qsg_pkg::HALF_Q29;
        return t >>> 29;
    endfunction

    // round half up and drop 30 fraction bits
    function automatic logic signed [qsg_pkg::PROD_W-1:0] rnd30(
        input logic signed [qsg_pkg::PROD_W-1:0] v
    );
        logic signed [qsg_pkg::PROD_W-1:0] t;
        t = v + qsg_pkg::HALF_Q30;
        return t >>> 30;
    endfunction

    // clamp to signed 32 bits
    function automatic logic signed [qsg_pkg::PHS_W-1:0] sat32(
        input logic signed [qsg_pkg::PROD_W-1:0] v
    );
        logic signed [qsg_pkg::PROD_W-1:0] t;
        t = v;
        if (v > qsg_pkg::SAT32_MAX) begin
            t = qsg_pkg::SAT32_MAX;
        end else if (v < qsg_pkg::SAT32_MIN) begin
            t = qsg_pkg::SAT32_MIN;
        end
        return t[qsg_pkg::PHS_W-1:0];
    endfunction

    // clamp to the output range
    function automatic logic signed [qsg_pkg::SMP_W-1:0] sat_smp(
        input logic signed [qsg_pkg::PROD_W-1:0] v
    );
        logic signed [qsg_pkg::PROD_W-1:0] t;
        t = v;
        if (v > qsg_pkg::OUT_LIMIT) begin
            t = qsg_pkg::OUT_LIMIT;
        end else if (v < qsg_pkg::OUT_LIMIT_N) begin
            t = qsg_pkg::OUT_LIMIT_N;
        end
        return t[qsg_pkg::SMP_W-1:0];
    endfunction

    logic signed [qsg_pkg::PHS_W-1:0]  phs_s_reg, phs_s_next;
    logic signed [qsg_pkg::PHS_W-1:0]  phs_c_reg, phs_c_next;
    logic signed [qsg_pkg::PHS_W-1:0]  ns_reg, ns_next;
    logic signed [qsg_pkg::PHS_W-1:0]  nc_reg, nc_next;
    logic signed [qsg_pkg::PHS_W-1:0]  corr_reg, corr_next;
    logic signed [qsg_pkg::MAG_W-1:0]  mag_reg, mag_next;
    logic signed [qsg_pkg::PROD_W-1:0] acc_reg, acc_next;
    logic signed [qsg_pkg::SMP_W-1:0]  smp_s_reg, smp_s_next;
    logic signed [qsg_pkg::SMP_W-1:0]  smp_c_reg, smp_c_next;

    logic signed [qsg_pkg::PHS_W-1:0]  op_a;
    logic signed [qsg_pkg::PHS_W-1:0]  op_b;
    logic signed [qsg_pkg::PROD_W-1:0] prod;

    logic signed [qsg_pkg::PHS_W-1:0]  gain_ext;
    logic signed [qsg_pkg::PHS_W-1:0]  sts_ext;
    logic signed [qsg_pkg::PHS_W-1:0]  stc_ext;
    logic signed [qsg_pkg::PROD_W-1:0] offs_ext;
    logic signed [qsg_pkg::PROD_W-1:0] mag_ext;
    logic signed [qsg_pkg::PROD_W-1:0] prod_r29;
    logic signed [qsg_pkg::PROD_W-1:0] smp_sum;
    logic signed [qsg_pkg::PROD_W-1:0] rot_sum;
    logic signed [qsg_pkg::PROD_W-1:0] rot_dif;
    logic signed [qsg_pkg::PROD_W-1:0] corr_raw;

    // operand extension
    assign gain_ext = {{(qsg_pkg::PHS_W-qsg_pkg::GAIN_W){1'b0}}, cfg.gain};
    assign sts_ext  = {{(qsg_pkg::PHS_W-qsg_pkg::STEP_W){cfg.step_sine[qsg_pkg::STEP_W-1]}},
                       cfg.step_sine};
    assign stc_ext  = {{(qsg_pkg::PHS_W-qsg_pkg::STEP_W){cfg.step_cosine[qsg_pkg::STEP_W-1]}},
                       cfg.step_cosine};
    assign offs_ext = {{(qsg_pkg::PROD_W-qsg_pkg::OFFS_W){cfg.offset[qsg_pkg::OFFS_W-1]}},
                       cfg.offset};
    assign mag_ext  = {{(qsg_pkg::PROD_W-qsg_pkg::MAG_W){mag_reg[qsg_pkg::MAG_W-1]}}, mag_reg};

    // operand select for the shared multiplier
    always_comb begin
        op_a = '0;
        op_b = '0;
        unique case (ctrl.op)
            qsg_pkg::OP_NONE: begin
            end
            qsg_pkg::OP_S_G: begin
                op_a = phs_s_reg;
                op_b = gain_ext;
            end
            qsg_pkg::OP_C_G: begin
                op_a = phs_c_reg;
                op_b = gain_ext;
            end
            qsg_pkg::OP_S_STC: begin
                op_a = phs_s_reg;
                op_b = stc_ext;
            end
            qsg_pkg::OP_C_STS: begin
                op_a = phs_c_reg;
                op_b = sts_ext;
            end
            qsg_pkg::OP_C_STC: begin
                op_a = phs_c_reg;
                op_b = stc_ext;
            end
            qsg_pkg::OP_S_STS: begin
                op_a = phs_s_reg;
                op_b = sts_ext;
            end
            qsg_pkg::OP_NS_NS: begin
                op_a = ns_reg;
                op_b = ns_reg;
            end
            qsg_pkg::OP_NC_NC: begin
                op_a = nc_reg;
                op_b = nc_reg;
            end
            qsg_pkg::OP_NS_CORR: begin
                op_a = ns_reg;
                op_b = corr_reg;
            end
            qsg_pkg::OP_NC_CORR: begin
                op_a = nc_reg;
                op_b = corr_reg;
            end
            default: begin
            end
        endcase
    end

    qsg_mult u_mult (
        .aclk (aclk),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    // product post-processing
    assign prod_r29 = rnd29(prod);
    assign smp_sum  = prod_r29 + offs_ext;
    assign rot_sum  = acc_reg + prod;
    assign rot_dif  = acc_reg - prod;
    assign corr_raw = qsg_pkg::THREE_Q29 - (mag_ext + prod_r29);

    // register updates per action
    always_comb begin
        phs_s_next = phs_s_reg;
        phs_c_next = phs_c_reg;
        ns_next    = ns_reg;
        nc_next    = nc_reg;
        corr_next  = corr_reg;
        mag_next   = mag_reg;
        acc_next   = acc_reg;
        smp_s_next = smp_s_reg;
        smp_c_next = smp_c_reg;
        unique case (ctrl.act)
            qsg_pkg::ACT_NONE:     begin end
            qsg_pkg::ACT_SMP_S:    smp_s_next = sat_smp(smp_sum);
            qsg_pkg::ACT_SMP_C:    smp_c_next = sat_smp(smp_sum);
            qsg_pkg::ACT_ACC_LOAD: acc_next   = prod + qsg_pkg::HALF_Q29;
            qsg_pkg::ACT_ROT_NS:   ns_next    = sat32(rot_sum >>> 29);
            qsg_pkg::ACT_ROT_NC:   nc_next    = sat32(rot_dif >>> 29);
            qsg_pkg::ACT_MAG_LOAD: mag_next   = qsg_pkg::MAG_W'(prod_r29);
            qsg_pkg::ACT_CORR:     corr_next  = sat32(corr_raw);
            qsg_pkg::ACT_NRM_NS:   ns_next    = sat32(rnd30(prod));
            qsg_pkg::ACT_NRM_NC:   nc_next    = sat32(rnd30(prod));
            default:               begin end
        endcase
        if (ctrl.commit) begin
            phs_s_next = ns_reg;
            phs_c_next = nc_reg;
        end
    end

    // phasor state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phs_s_reg <= '0;
            phs_c_reg <= qsg_pkg::ONE_Q29;
        end else begin
            phs_s_reg <= phs_s_next;
            phs_c_reg <= phs_c_next;
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        ns_reg    <= ns_next;
        nc_reg    <= nc_next;
        corr_reg  <= corr_next;
        mag_reg   <= mag_next;
        acc_reg   <= acc_next;
        smp_s_reg <= smp_s_next;
        smp_c_reg <= smp_c_next;
    end

    assign smp_s = smp_s_reg;
    assign smp_c = smp_c_reg;

    // the phasor moves only at the end of a tick
    a_phasor_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (aresetn && !ctrl.commit) |=> ($stable(phs_s_reg) && $stable(phs_c_reg)))
        else $error("phasor changed outside of commit");

endmodule
